### hdl/fem_shape_gradient_3d_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shape gradient block.
// They rely on clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef FEM_SHAPE_GRADIENT_3D_TOP_DEFINES_SVH
`define FEM_SHAPE_GRADIENT_3D_TOP_DEFINES_SVH

`define FSG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define FSG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define FSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg
// Types, constants and arithmetic helpers of the shape gradient block.
// ----------------------------------------------------------------------------
package fsg_pkg;

  localparam int MAX_NODES = 32;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int Q_FRAC    = 16;
  localparam int DIV_W     = 32 + Q_FRAC;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int STORE_W   = 96;

  typedef struct packed {
    logic signed [31:0] deriv_r;
    logic signed [31:0] deriv_s;
    logic signed [31:0] deriv_t;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               last_node;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         node_index;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic signed [31:0] jacobian_det;
    logic               singular;
    logic               last_out;
  } out_item_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ACC  = 8'b0000_0010,
    S_ADJ  = 8'b0000_0100,
    S_DET  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_RD   = 8'b0010_0000,
    S_GRD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  typedef logic [3:0] midx_t;

  localparam logic [1:0] ROW_OF [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] COL_OF [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam midx_t INV_T_IDX [9] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};
  localparam midx_t DET_ADJ_IDX [3] = '{4'd0, 4'd3, 4'd6};

  localparam midx_t ADJ_A1 [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam midx_t ADJ_B1 [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam midx_t ADJ_A2 [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam midx_t ADJ_B2 [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  function automatic logic signed [65:0] trunc16(input logic signed [65:0] x);
    logic signed [65:0] b;
    b = x + (x[65] ? 66'sd65535 : 66'sd0);
    return b >>> Q_FRAC;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/fsg_in_if.sv
// ----------------------------------------------------------------------------
// fsg_in_if
// Node channel: valid, ready and one node item.
// ----------------------------------------------------------------------------
interface fsg_in_if;
  logic               valid;
  logic               ready;
  fsg_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/fsg_out_if.sv
// ----------------------------------------------------------------------------
// fsg_out_if
// Gradient channel: valid, ready and one gradient item.
// ----------------------------------------------------------------------------
interface fsg_out_if;
  logic               valid;
  logic               ready;
  fsg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/fsg_ram.sv
// ----------------------------------------------------------------------------
// fsg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### hdl/fsg_mul.sv
// ----------------------------------------------------------------------------
// fsg_mul
// Shared signed 32 by 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module fsg_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod_r
);

  logic signed [63:0] prod_nxt;

  assign prod_nxt = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### hdl/fsg_div.sv
// ----------------------------------------------------------------------------
// fsg_div
// Bit-serial signed divider: saturates (n * 2^16) / d to 32 bits, truncating.
// ----------------------------------------------------------------------------
module fsg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] numer,
  input  logic signed [31:0] denom,
  output logic               done_r,
  output logic signed [31:0] quot
);

  logic [fsg_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [31:0]                   rem_r, rem_nxt;
  logic [31:0]                   dvs_r;
  logic                          neg_r;
  logic [fsg_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          done_nxt;
  logic [32:0]                   rem_s;
  logic [31:0]                   mag_n, mag_d;

  assign mag_n = numer[31] ? 32'(-numer) : 32'(numer);
  assign mag_d = denom[31] ? 32'(-denom) : 32'(denom);
  assign rem_s = {rem_r, quo_r[fsg_pkg::DIV_W-1]};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = {mag_n, {fsg_pkg::Q_FRAC{1'b0}}};
      rem_nxt = '0;
      cnt_nxt = fsg_pkg::DIV_CNT_W'(fsg_pkg::DIV_W);
    end else if (cnt_r != '0) begin
      if (rem_s >= {1'b0, dvs_r}) begin
        rem_nxt = 32'(rem_s - {1'b0, dvs_r});
        quo_nxt = {quo_r[fsg_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_s[31:0];
        quo_nxt = {quo_r[fsg_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == fsg_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= mag_d;
      neg_r <= numer[31] ^ denom[31];
    end
  end

  always_comb begin
    if (neg_r) begin
      if (quo_r > fsg_pkg::DIV_W'(33'h0_8000_0000)) begin
        quot = 32'sh8000_0000;
      end else begin
        quot = 32'(-quo_r);
      end
    end else begin
      if (quo_r > fsg_pkg::DIV_W'(32'h7FFF_FFFF)) begin
        quot = 32'sh7FFF_FFFF;
      end else begin
        quot = quo_r[31:0];
      end
    end
  end

endmodule

### hdl/fem_shape_gradient_3d_top.sv
// ----------------------------------------------------------------------------
// fem_shape_gradient_3d_top: Jacobian inverse and physical shape gradients.
// A node takes nine products through one shared multiplier.
// A last node adds the adjugate, determinant and nine 48-step divisions (skipped
// for a singular element), then each node's gradient, which an output stall holds.
// Reset clears the controller, node count and Jacobian; the store is not cleared.
// ----------------------------------------------------------------------------
module fem_shape_gradient_3d_top (
  input  logic        clk,
  input  logic        rst_n,
  fsg_in_if.sink      in_ch,
  fsg_out_if.source   out_ch
);

  fsg_pkg::state_t state_r, state_nxt;

  logic [fsg_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [fsg_pkg::CNT_W-1:0] p_r, p_nxt;
  logic [3:0]                k_r, k_nxt;
  logic [1:0]                ph_r, ph_nxt;

  logic signed [31:0] d_r [3];
  logic signed [31:0] c_r [3];
  logic               last_r;
  logic signed [63:0] jac_r [9];
  logic signed [31:0] adj_r [9];
  logic signed [31:0] inv_r [9];
  logic signed [63:0] p1_r;
  logic signed [63:0] det_acc_r;
  logic signed [31:0] det_r;
  logic signed [63:0] gacc_r;
  logic signed [31:0] grad_r [3];

  logic                           in_fire, out_fire, has_room;
  logic signed [31:0]             mul_a, mul_b;
  logic signed [63:0]             prod_r;
  logic signed [63:0]             term;
  logic                           div_start, div_done;
  logic signed [31:0]             div_q;
  logic [fsg_pkg::STORE_W-1:0]    rd_data;
  logic                           rd_en;
  logic signed [31:0]             dr_sel;

  function automatic logic signed [31:0] jsat(input logic signed [63:0] v);
    return fsg_pkg::sat32(66'(v));
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign has_room = count_r < fsg_pkg::CNT_W'(fsg_pkg::MAX_NODES);
  assign in_ch.ready = (state_r == fsg_pkg::S_IDLE);
  assign term = 64'(fsg_pkg::trunc16(66'(prod_r)));
  assign rd_en = (state_r == fsg_pkg::S_RD);
  assign div_start = (state_r == fsg_pkg::S_DIV) && (ph_r == 2'd0) && (det_r != 32'sd0);

  fsg_ram #(
    .WIDTH (fsg_pkg::STORE_W),
    .DEPTH (fsg_pkg::MAX_NODES)
  ) u_store (
    .clk     (clk),
    .we      (in_fire && has_room),
    .waddr   (count_r[fsg_pkg::ADDR_W-1:0]),
    .wdata   ({in_ch.data.deriv_t, in_ch.data.deriv_s, in_ch.data.deriv_r}),
    .re      (rd_en),
    .raddr   (p_r[fsg_pkg::ADDR_W-1:0]),
    .rdata_r (rd_data)
  );

  fsg_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  fsg_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .numer  (adj_r[k_r]),
    .denom  (det_r),
    .done_r (div_done),
    .quot   (div_q)
  );

  always_comb begin
    unique case (fsg_pkg::COL_OF[k_r])
      2'd0:    dr_sel = rd_data[31:0];
      2'd1:    dr_sel = rd_data[63:32];
      default: dr_sel = rd_data[95:64];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      fsg_pkg::S_ACC: begin
        mul_a = d_r[fsg_pkg::COL_OF[k_r]];
        mul_b = c_r[fsg_pkg::ROW_OF[k_r]];
      end
      fsg_pkg::S_ADJ: begin
        if (ph_r == 2'd0) begin
          mul_a = jsat(jac_r[fsg_pkg::ADJ_A1[k_r]]);
          mul_b = jsat(jac_r[fsg_pkg::ADJ_B1[k_r]]);
        end else begin
          mul_a = jsat(jac_r[fsg_pkg::ADJ_A2[k_r]]);
          mul_b = jsat(jac_r[fsg_pkg::ADJ_B2[k_r]]);
        end
      end
      fsg_pkg::S_DET: begin
        mul_a = jsat(jac_r[k_r]);
        mul_b = adj_r[fsg_pkg::DET_ADJ_IDX[k_r[1:0]]];
      end
      fsg_pkg::S_GRD: begin
        mul_a = dr_sel;
        mul_b = inv_r[fsg_pkg::INV_T_IDX[k_r]];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      fsg_pkg::S_IDLE: begin
        if (in_fire) begin
          k_nxt  = '0;
          ph_nxt = '0;
          if (has_room) begin
            count_nxt = count_r + 1'b1;
            state_nxt = fsg_pkg::S_ACC;
          end else if (in_ch.data.last_node) begin
            state_nxt = fsg_pkg::S_ADJ;
          end
        end
      end
      fsg_pkg::S_ACC: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (k_r == 4'd8) begin
            k_nxt = '0;
            state_nxt = last_r ? fsg_pkg::S_ADJ : fsg_pkg::S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      fsg_pkg::S_ADJ: begin
        if (ph_r != 2'd2) begin
          ph_nxt = ph_r + 1'b1;
        end else begin
          ph_nxt = 2'd0;
          if (k_r == 4'd8) begin
            k_nxt = '0;
            state_nxt = fsg_pkg::S_DET;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      fsg_pkg::S_DET: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (k_r == 4'd2) begin
            k_nxt = '0;
            state_nxt = fsg_pkg::S_DIV;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      fsg_pkg::S_DIV: begin
        if (ph_r == 2'd0) begin
          if (det_r == 32'sd0) begin
            p_nxt = '0;
            state_nxt = fsg_pkg::S_RD;
          end else begin
            ph_nxt = 2'd1;
          end
        end else if (div_done) begin
          ph_nxt = 2'd0;
          if (k_r == 4'd8) begin
            k_nxt = '0;
            p_nxt = '0;
            state_nxt = fsg_pkg::S_RD;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      fsg_pkg::S_RD: begin
        k_nxt  = '0;
        ph_nxt = '0;
        state_nxt = fsg_pkg::S_GRD;
      end
      fsg_pkg::S_GRD: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (k_r == 4'd8) begin
            k_nxt = '0;
            state_nxt = fsg_pkg::S_OUT;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      fsg_pkg::S_OUT: begin
        if (out_fire) begin
          if (p_r + 1'b1 == count_r) begin
            count_nxt = '0;
            state_nxt = fsg_pkg::S_IDLE;
          end else begin
            p_nxt = p_r + 1'b1;
            state_nxt = fsg_pkg::S_RD;
          end
        end
      end
      default: state_nxt = fsg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsg_pkg::S_IDLE;
      count_r <= '0;
      p_r     <= '0;
      k_r     <= '0;
      ph_r    <= '0;
      for (int i = 0; i < 9; i++) begin
        jac_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      p_r     <= p_nxt;
      k_r     <= k_nxt;
      ph_r    <= ph_nxt;
      if (state_r == fsg_pkg::S_ACC && ph_r == 2'd1) begin
        jac_r[k_r] <= jac_r[k_r] + term;
      end
      if (out_fire && (p_r + 1'b1 == count_r)) begin
        for (int i = 0; i < 9; i++) begin
          jac_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      d_r[0] <= in_ch.data.deriv_r;
      d_r[1] <= in_ch.data.deriv_s;
      d_r[2] <= in_ch.data.deriv_t;
      c_r[0] <= in_ch.data.coord_x;
      c_r[1] <= in_ch.data.coord_y;
      c_r[2] <= in_ch.data.coord_z;
      last_r <= in_ch.data.last_node;
    end
    if (state_r == fsg_pkg::S_ADJ) begin
      if (ph_r == 2'd1) begin
        p1_r <= prod_r;
      end
      if (ph_r == 2'd2) begin
        adj_r[k_r] <= fsg_pkg::sat32(fsg_pkg::trunc16(66'(p1_r) - 66'(prod_r)));
      end
      det_acc_r <= '0;
    end
    if (state_r == fsg_pkg::S_DET && ph_r == 2'd1) begin
      det_acc_r <= det_acc_r + term;
      if (k_r == 4'd2) begin
        det_r <= fsg_pkg::sat32(66'(det_acc_r + term));
      end
    end
    if (state_r == fsg_pkg::S_DIV && ph_r == 2'd1 && div_done) begin
      inv_r[k_r] <= div_q;
    end
    if (state_r == fsg_pkg::S_RD) begin
      gacc_r <= '0;
    end
    if (state_r == fsg_pkg::S_GRD && ph_r == 2'd1) begin
      if (fsg_pkg::COL_OF[k_r] == 2'd2) begin
        grad_r[fsg_pkg::ROW_OF[k_r]] <= fsg_pkg::sat32(66'(gacc_r + term));
        gacc_r <= '0;
      end else begin
        gacc_r <= gacc_r + term;
      end
    end
  end

  assign out_ch.valid = (state_r == fsg_pkg::S_OUT);
  assign out_ch.data.node_index   = 5'(p_r);
  assign out_ch.data.grad_x       = (det_r == 32'sd0) ? 32'sd0 : grad_r[0];
  assign out_ch.data.grad_y       = (det_r == 32'sd0) ? 32'sd0 : grad_r[1];
  assign out_ch.data.grad_z       = (det_r == 32'sd0) ? 32'sd0 : grad_r[2];
  assign out_ch.data.jacobian_det = det_r;
  assign out_ch.data.singular     = (det_r == 32'sd0);
  assign out_ch.data.last_out     = (p_r + 1'b1 == count_r);

`include "fem_shape_gradient_3d_top_defines.svh"

  `FSG_ASSERT_ALWAYS(a_count_bound, count_r <= fsg_pkg::CNT_W'(fsg_pkg::MAX_NODES), "node count overflow")
  `FSG_ASSERT_SAME(a_emit_in_range, out_ch.valid, p_r < count_r, "gradient index beyond node count")
  `FSG_ASSERT_SAME(a_singular_zero, out_ch.valid && out_ch.data.singular, (out_ch.data.grad_x == 32'sd0) && (out_ch.data.grad_y == 32'sd0) && (out_ch.data.grad_z == 32'sd0), "singular element with nonzero gradient")
  `FSG_ASSERT_NEXT(a_element_close, out_fire && out_ch.data.last_out, (count_r == '0) && (jac_r[0] == 64'sd0) && in_ch.ready, "element not closed after last transaction")

endmodule

### bench/fsg_gradient_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape gradient checker
// Watches the node and gradient channels, predicts the gradients of each
// element from the accepted nodes, and compares every gradient transaction
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fsg_gradient_checker (
  input  logic clk,
  input  logic rst_n,
  fsg_in_if    in_mon,
  fsg_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);

  localparam longint Q_ONE = 65536;

  logic signed [31:0] held_r [fsg_pkg::MAX_NODES];
  logic signed [31:0] held_s [fsg_pkg::MAX_NODES];
  logic signed [31:0] held_t [fsg_pkg::MAX_NODES];
  longint             jac_acc [9];
  int                 held_nodes;
  fsg_pkg::out_item_t grad_queue [$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic close_element();
    longint             a [9];
    longint             adj [9];
    longint             inv [9];
    longint             det;
    longint             dr [3];
    longint             acc;
    fsg_pkg::out_item_t o;
    for (int k = 0; k < 9; k++) a[k] = clamp32(jac_acc[k]);
    adj[0] = clamp32((a[4] * a[8] - a[5] * a[7]) / Q_ONE);
    adj[1] = clamp32((a[2] * a[7] - a[1] * a[8]) / Q_ONE);
    adj[2] = clamp32((a[1] * a[5] - a[2] * a[4]) / Q_ONE);
    adj[3] = clamp32((a[5] * a[6] - a[3] * a[8]) / Q_ONE);
    adj[4] = clamp32((a[0] * a[8] - a[2] * a[6]) / Q_ONE);
    adj[5] = clamp32((a[2] * a[3] - a[0] * a[5]) / Q_ONE);
    adj[6] = clamp32((a[3] * a[7] - a[4] * a[6]) / Q_ONE);
    adj[7] = clamp32((a[1] * a[6] - a[0] * a[7]) / Q_ONE);
    adj[8] = clamp32((a[0] * a[4] - a[1] * a[3]) / Q_ONE);
    det = clamp32((a[0] * adj[0]) / Q_ONE + (a[1] * adj[3]) / Q_ONE +
                  (a[2] * adj[6]) / Q_ONE);
    for (int k = 0; k < 9; k++) inv[k] = (det == 0) ? 0 : clamp32((adj[k] * Q_ONE) / det);
    for (int p = 0; p < held_nodes; p++) begin
      dr[0] = held_r[p];
      dr[1] = held_s[p];
      dr[2] = held_t[p];
      o.node_index = p[4:0];
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += (dr[j] * inv[j * 3 + i]) / Q_ONE;
        acc = (det == 0) ? 0 : clamp32(acc);
        if (i == 0) o.grad_x = acc[31:0];
        else if (i == 1) o.grad_y = acc[31:0];
        else o.grad_z = acc[31:0];
      end
      o.jacobian_det = det[31:0];
      o.singular     = (det == 0);
      o.last_out     = (p + 1 == held_nodes);
      grad_queue.push_back(o);
    end
    for (int k = 0; k < 9; k++) jac_acc[k] = 0;
    held_nodes = 0;
  endtask

  task automatic take_node(input fsg_pkg::in_item_t n);
    longint d [3];
    longint c [3];
    d[0] = n.deriv_r; d[1] = n.deriv_s; d[2] = n.deriv_t;
    c[0] = n.coord_x; c[1] = n.coord_y; c[2] = n.coord_z;
    if (held_nodes < fsg_pkg::MAX_NODES) begin
      held_r[held_nodes] = n.deriv_r;
      held_s[held_nodes] = n.deriv_s;
      held_t[held_nodes] = n.deriv_t;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) jac_acc[i * 3 + j] += (d[j] * c[i]) / Q_ONE;
      held_nodes++;
    end
    if (n.last_node) close_element();
  endtask

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    held_nodes = 0;
    for (int k = 0; k < 9; k++) jac_acc[k] = 0;
  end

  always @(posedge clk) begin
    fsg_pkg::out_item_t e;
    fsg_pkg::out_item_t a;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        a = out_mon.data;
        if (grad_queue.size() == 0) begin
          $display("%0t: unexpected gradient transaction, actual node %0d", $time,
                   a.node_index);
          fail_count++;
        end else begin
          e = grad_queue.pop_front();
          check_field("node_index", e.node_index, a.node_index);
          check_field("grad_x", e.grad_x, a.grad_x);
          check_field("grad_y", e.grad_y, a.grad_y);
          check_field("grad_z", e.grad_z, a.grad_z);
          check_field("jacobian_det", e.jacobian_det, a.jacobian_det);
          check_field("singular", e.singular, a.singular);
          check_field("last_out", e.last_out, a.last_out);
        end
      end
      if (in_mon.valid && in_mon.ready) take_node(in_mon.data);
    end
    pending_count = grad_queue.size();
  end
endmodule

### bench/tb_fem_shape_gradient_3d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape gradient block testbench
// Sends directed and random elements in bursts with random gaps, stalls the
// gradient channel on changing patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_fem_shape_gradient_3d_top;

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;
  int   taken_count = 0;
  int   shown_idx = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   stall_cnt = 0;
  bit   driving = 1'b0;
  fsg_pkg::in_item_t node_queue [$];

  fsg_in_if  in_ch ();
  fsg_out_if out_ch ();

  fem_shape_gradient_3d_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  fsg_gradient_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic signed [31:0] pick_value(input int mode, input int span);
    case (mode)
      0: return $signed($urandom_range(0, 2 * span)) - span;
      1: return $urandom();
      default: return 0;
    endcase
  endfunction

  task automatic add_node(input int dr, input int ds, input int dt, input int cx,
                          input int cy, input int cz, input bit last);
    fsg_pkg::in_item_t n;
    n.deriv_r = dr; n.deriv_s = ds; n.deriv_t = dt;
    n.coord_x = cx; n.coord_y = cy; n.coord_z = cz;
    n.last_node = last;
    node_queue.push_back(n);
  endtask

  task automatic add_random_element(input int size);
    int dmode;
    int cmode;
    dmode = ($urandom_range(0, 9) < 8) ? 0 : 1;
    case ($urandom_range(0, 19))
      0:       cmode = 2;
      1, 2, 3: cmode = 1;
      default: cmode = 0;
    endcase
    for (int k = 0; k < size; k++)
      add_node(pick_value(dmode, 2 * ONE), pick_value(dmode, 2 * ONE), pick_value(dmode, 2 * ONE),
               pick_value(cmode, 10 * ONE), pick_value(cmode, 10 * ONE),
               pick_value(cmode, 10 * ONE), k == size - 1);
  endtask

  initial begin
    int size;
    add_node(ONE, 0, 0, ONE, 0, 0, 1'b0);
    add_node(0, ONE, 0, 0, ONE, 0, 1'b0);
    add_node(0, 0, ONE, 0, 0, ONE, 1'b1);
    add_node(2 * ONE, 0, 0, ONE / 2, 0, 0, 1'b0);
    add_node(0, -ONE, 0, 0, 3 * ONE, 0, 1'b0);
    add_node(0, 0, ONE / 4, 0, 0, -5 * ONE, 1'b1);
    add_node(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
    add_node(32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
    add_node(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 1, 1'b1);
    add_node(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 1'b0);
    add_node(-ONE, ONE, -ONE, 0, 0, 0, 1'b1);
    add_node(ONE, ONE, ONE, ONE, ONE, ONE, 1'b0);
    add_node(2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE, 1'b1);
    add_node(ONE, 0, 0, 100 * ONE, 0, 0, 1'b0);
    add_node(0, ONE, 0, 0, 100 * ONE, 0, 1'b0);
    add_node(0, 0, ONE, 0, 0, 100 * ONE, 1'b1);
    add_node(-1, 1, -1, 1, -1, 1, 1'b1);
    while (node_queue.size() < 310) begin
      case ($urandom_range(0, 19))
        0:       size = $urandom_range(fsg_pkg::MAX_NODES + 1, fsg_pkg::MAX_NODES + 3);
        1:       size = fsg_pkg::MAX_NODES;
        2, 3:    size = $urandom_range(9, fsg_pkg::MAX_NODES - 1);
        default: size = $urandom_range(1, 8);
      endcase
      add_random_element(size);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    driving = 1'b1;
    wait (taken_count == node_queue.size());
    @(posedge clk);
    wait (pending_count == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_ch.valid && in_ch.ready) taken_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    bit                next_valid;
    fsg_pkg::in_item_t next_data;
    next_valid = in_ch.valid;
    next_data  = in_ch.data;
    if (driving && (!in_ch.valid || taken_count > shown_idx)) begin
      if (gap_left > 0) begin
        gap_left--;
        next_valid = 1'b0;
      end else if (taken_count < node_queue.size()) begin
        shown_idx  = taken_count;
        next_data  = node_queue[shown_idx];
        next_valid = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        next_valid = 1'b0;
      end
    end
    in_ch.valid <= next_valid;
    in_ch.data  <= next_data;
  end

  always @(negedge clk) begin
    bit next_ready;
    stall_cnt++;
    if (stall_cnt % 300 == 0) stall_mode = $urandom_range(0, 4);
    case (stall_mode)
      0:       next_ready = 1'b1;
      1:       next_ready = (stall_cnt % 3) != 0;
      2:       next_ready = ((stall_cnt >> 3) & 1) == 1;
      3:       next_ready = ($urandom_range(0, 1) == 1);
      default: next_ready = (stall_cnt % 23) > 17;
    endcase
    out_ch.ready <= next_ready;
  end
endmodule

### sim.f
+incdir+hdl
hdl/fsg_pkg.sv
hdl/fsg_in_if.sv
hdl/fsg_out_if.sv
hdl/fsg_ram.sv
hdl/fsg_mul.sv
hdl/fsg_div.sv
hdl/fem_shape_gradient_3d_top.sv
bench/fsg_gradient_checker.sv
bench/tb_fem_shape_gradient_3d_top.sv
